// ===== hdl/ethernet_ip_header_classifier_defines.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef ETHERNET_IP_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_IP_HEADER_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define EIPHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("classifier check failed in the same cycle");
`define EIPHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("classifier check failed one cycle later");
`else
`define EIPHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define EIPHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/eiphc_pkg.sv =====
package eiphc_pkg;

  typedef enum logic [2:0] {
    CLASS_IP      = 3'd0,
    CLASS_ARP     = 3'd1,
    CLASS_STP     = 3'd2,
    CLASS_CDP     = 3'd3,
    CLASS_IPX     = 3'd4,
    CLASS_UNKNOWN = 3'd5
  } frame_class_e;

  localparam logic [15:0] ETHERTYPE_IP    = 16'h0800;
  localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETHERTYPE_STP   = 16'h0026;
  localparam logic [15:0] ETHERTYPE_CDP   = 16'h012c;
  localparam logic [15:0] ETHERTYPE_IPX_0 = 16'h002c;
  localparam logic [15:0] ETHERTYPE_IPX_1 = 16'h0054;
  localparam logic [15:0] ETHERTYPE_IPX_2 = 16'h00be;
  localparam logic [15:0] ETHERTYPE_IPX_3 = 16'h00dc;
  localparam logic [15:0] ETHERTYPE_IPX_4 = 16'h00ca;
  localparam logic [15:0] ETHERTYPE_IPX_5 = 16'h00c2;
  localparam logic [15:0] ETHERTYPE_IPX_6 = 16'h00a4;
  localparam logic [15:0] ETHERTYPE_IPX_7 = 16'h00c0;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [15:0] POS_TYPE_HI    = 16'd12;
  localparam logic [15:0] POS_TYPE_LO    = 16'd13;
  localparam logic [15:0] POS_L3_START   = 16'd14;
  localparam logic [15:0] POS_PROTOCOL   = 16'd23;
  localparam logic [15:0] POS_IP_SRC_LO  = 16'd26;
  localparam logic [15:0] POS_IP_SRC_HI  = 16'd29;
  localparam logic [15:0] POS_IP_DST_LO  = 16'd30;
  localparam logic [15:0] POS_IP_DST_HI  = 16'd33;
  localparam logic [15:0] POS_ARP_OP_HI  = 16'd20;
  localparam logic [15:0] POS_ARP_OP_LO  = 16'd21;
  localparam logic [15:0] POS_ARP_SRC_LO = 16'd28;
  localparam logic [15:0] POS_ARP_SRC_HI = 16'd31;
  localparam logic [15:0] POS_ARP_DST_LO = 16'd38;
  localparam logic [15:0] POS_ARP_DST_HI = 16'd41;
  localparam logic [6:0]  TRANSPORT_BASE = 7'd14;

  localparam logic [3:0] SEEN_TYPE  = 4'b0001;
  localparam logic [3:0] SEEN_ADDR  = 4'b0010;
  localparam logic [3:0] SEEN_PORTS = 4'b0100;
  localparam logic [3:0] SEEN_MSG   = 4'b1000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  frame_class;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic        ports_valid;
    logic [15:0] arp_operation;
    logic        message_known;
    logic [3:0]  message_index;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    logic       known;
    logic [3:0] index;
  } msg_lookup_t;

  function automatic frame_class_e class_of(input logic [15:0] t);
    frame_class_e c;
    case (t)
      ETHERTYPE_IP:    c = CLASS_IP;
      ETHERTYPE_ARP:   c = CLASS_ARP;
      ETHERTYPE_STP:   c = CLASS_STP;
      ETHERTYPE_CDP:   c = CLASS_CDP;
      ETHERTYPE_IPX_0, ETHERTYPE_IPX_1, ETHERTYPE_IPX_2, ETHERTYPE_IPX_3,
      ETHERTYPE_IPX_4, ETHERTYPE_IPX_5, ETHERTYPE_IPX_6, ETHERTYPE_IPX_7:
        c = CLASS_IPX;
      default:         c = CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic msg_lookup_t icmp_lookup(input logic [7:0] v);
    msg_lookup_t r;
    r.known = 1'b1;
    case (v)
      8'd0:    r.index = 4'd0;
      8'd3:    r.index = 4'd1;
      8'd4:    r.index = 4'd2;
      8'd5:    r.index = 4'd3;
      8'd6:    r.index = 4'd4;
      8'd8:    r.index = 4'd5;
      8'd9:    r.index = 4'd6;
      8'd10:   r.index = 4'd7;
      8'd11:   r.index = 4'd8;
      8'd12:   r.index = 4'd9;
      8'd13:   r.index = 4'd10;
      8'd14:   r.index = 4'd11;
      8'd15:   r.index = 4'd12;
      8'd16:   r.index = 4'd13;
      8'd17:   r.index = 4'd14;
      8'd18:   r.index = 4'd15;
      default: begin
        r.known = 1'b0;
        r.index = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic msg_lookup_t igmp_lookup(input logic [7:0] v);
    msg_lookup_t r;
    r.known = 1'b1;
    case (v)
      8'h11:   r.index = 4'd0;
      8'h12:   r.index = 4'd1;
      8'h13:   r.index = 4'd2;
      8'h14:   r.index = 4'd3;
      8'h15:   r.index = 4'd4;
      8'h16:   r.index = 4'd5;
      8'h17:   r.index = 4'd6;
      8'h1e:   r.index = 4'd7;
      8'h1f:   r.index = 4'd8;
      8'h22:   r.index = 4'd9;
      8'h24:   r.index = 4'd10;
      8'h25:   r.index = 4'd11;
      8'h26:   r.index = 4'd12;
      default: begin
        r.known = 1'b0;
        r.index = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ethernet_ip_header_classifier.sv =====
// Frame bytes enter one per clock while in_stall_o is low, starting at the
// destination MAC, and a transaction is accepted in every cycle in which
// in_valid_i is high and in_stall_o is low. The byte that carries end_of_frame
// produces one summary transaction on the output in the cycle after it is
// accepted, from a single result register; all other bytes produce none. The
// input is stalled only while that result register holds an untaken summary
// and out_stall_i is high, so frames may follow each other without a gap.
`include "ethernet_ip_header_classifier_defines.svh"

module ethernet_ip_header_classifier
  import eiphc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef struct packed {
    logic [15:0] byte_position;
    logic [15:0] ether_type_word;
    logic [6:0]  transport_offset;
    logic [7:0]  protocol_held;
    logic [31:0] source_held;
    logic [31:0] destination_held;
    logic [31:0] ports_held;
    logic [15:0] operation_held;
    logic [7:0]  message_type_held;
    logic [3:0]  fields_seen;
  } frame_state_t;

  frame_state_t state_q, state_d, upd;
  out_item_t    out_q, res;
  logic         out_valid_q, out_valid_d;
  logic         in_accept;
  frame_class_e cls;
  logic [7:0]   b;
  logic [15:0]  pos;
  logic [15:0]  tr_lo, tr_hi;
  logic         tcpudp, msg;
  msg_lookup_t  icmp_r, igmp_r;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign b          = in_data_i.data_byte;
  assign pos        = state_q.byte_position;

  always_comb begin
    upd = state_q;
    if (pos == POS_TYPE_HI) begin
      upd.ether_type_word = {b, state_q.ether_type_word[7:0]};
    end
    if (pos == POS_TYPE_LO) begin
      upd.ether_type_word = {state_q.ether_type_word[15:8], b};
      upd.fields_seen     = state_q.fields_seen | SEEN_TYPE;
    end
    cls = ((upd.fields_seen & SEEN_TYPE) != 4'd0) ? class_of(upd.ether_type_word)
                                                 : CLASS_UNKNOWN;
    if (pos == POS_L3_START && cls != CLASS_ARP && cls != CLASS_UNKNOWN) begin
      upd.transport_offset = TRANSPORT_BASE + {1'b0, b[3:0], 2'b00};
    end
    tr_lo = {9'd0, upd.transport_offset};
    tr_hi = tr_lo + 16'd3;

    if (pos >= POS_L3_START && cls == CLASS_ARP) begin
      if (pos == POS_ARP_OP_HI || pos == POS_ARP_OP_LO) begin
        upd.operation_held = {state_q.operation_held[7:0], b};
      end
      if (pos >= POS_ARP_SRC_LO && pos <= POS_ARP_SRC_HI) begin
        upd.source_held = {state_q.source_held[23:0], b};
      end
      if (pos >= POS_ARP_DST_LO && pos <= POS_ARP_DST_HI) begin
        upd.destination_held = {state_q.destination_held[23:0], b};
      end
      if (pos == POS_ARP_DST_HI) begin
        upd.fields_seen = upd.fields_seen | SEEN_ADDR;
      end
    end else if (pos >= POS_L3_START && cls != CLASS_UNKNOWN) begin
      if (pos == POS_PROTOCOL) begin
        upd.protocol_held = b;
      end
      if (pos >= POS_IP_SRC_LO && pos <= POS_IP_SRC_HI) begin
        upd.source_held = {state_q.source_held[23:0], b};
      end
      if (pos >= POS_IP_DST_LO && pos <= POS_IP_DST_HI) begin
        upd.destination_held = {state_q.destination_held[23:0], b};
      end
      if (pos == POS_IP_DST_HI) begin
        upd.fields_seen = upd.fields_seen | SEEN_ADDR;
      end
      if (pos >= tr_lo && pos <= tr_hi) begin
        upd.ports_held = {state_q.ports_held[23:0], b};
        if (pos == tr_lo) begin
          upd.message_type_held = b;
          upd.fields_seen       = upd.fields_seen | SEEN_MSG;
        end
        if (pos == tr_hi) begin
          upd.fields_seen = upd.fields_seen | SEEN_PORTS;
        end
      end
    end

    upd.byte_position = (pos != 16'hffff) ? pos + 16'd1 : pos;
  end

  // The last byte of a frame returns every field to its reset value.
  assign state_d = in_data_i.end_of_frame ? '0 : upd;

  assign tcpudp = upd.protocol_held == PROTO_TCP || upd.protocol_held == PROTO_UDP;
  assign msg    = upd.protocol_held == PROTO_ICMP || upd.protocol_held == PROTO_IGMP;
  assign icmp_r = icmp_lookup(upd.message_type_held);
  assign igmp_r = igmp_lookup(upd.message_type_held);

  always_comb begin
    res             = '0;
    res.frame_class = cls;
    if ((upd.fields_seen & SEEN_TYPE) == 4'd0) begin
      res.truncated = 1'b1;
    end else if (cls == CLASS_ARP) begin
      if ((upd.fields_seen & SEEN_ADDR) == 4'd0) begin
        res.truncated = 1'b1;
      end else begin
        res.source_address      = upd.source_held;
        res.destination_address = upd.destination_held;
        res.arp_operation       = upd.operation_held;
      end
    end else if (cls != CLASS_UNKNOWN) begin
      if ((upd.fields_seen & SEEN_ADDR) == 4'd0 ||
          (tcpudp && (upd.fields_seen & SEEN_PORTS) == 4'd0) ||
          (msg && (upd.fields_seen & SEEN_MSG) == 4'd0)) begin
        res.truncated = 1'b1;
      end else begin
        res.protocol            = upd.protocol_held;
        res.source_address      = upd.source_held;
        res.destination_address = upd.destination_held;
        if (tcpudp) begin
          res.source_port      = upd.ports_held[31:16];
          res.destination_port = upd.ports_held[15:0];
          res.ports_valid      = 1'b1;
        end
        if (upd.protocol_held == PROTO_ICMP) begin
          res.message_known = icmp_r.known;
          res.message_index = icmp_r.index;
        end
        if (upd.protocol_held == PROTO_IGMP) begin
          res.message_known = igmp_r.known;
          res.message_index = igmp_r.index;
        end
      end
    end
  end

  assign out_valid_d = (in_accept && in_data_i.end_of_frame) ||
                       (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_data_i.end_of_frame) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `EIPHC_ASSERT_NEXT(a_eof_gives_result, clk_i, rst_ni, in_accept && in_data_i.end_of_frame, out_valid_q)
  `EIPHC_ASSERT_NEXT(a_eof_clears_state, clk_i, rst_ni, in_accept && in_data_i.end_of_frame, state_q.byte_position == 16'd0 && state_q.fields_seen == 4'd0)
  `EIPHC_ASSERT_IMPL(a_truncated_is_bare, clk_i, rst_ni, out_valid_q && out_q.truncated, out_q.protocol == 8'd0 && out_q.source_address == 32'd0 && out_q.destination_address == 32'd0 && !out_q.ports_valid && out_q.arp_operation == 16'd0 && !out_q.message_known)
  `EIPHC_ASSERT_IMPL(a_ports_need_tcpudp, clk_i, rst_ni, out_valid_q && out_q.ports_valid, out_q.protocol == PROTO_TCP || out_q.protocol == PROTO_UDP)
  `EIPHC_ASSERT_IMPL(a_message_needs_proto, clk_i, rst_ni, out_valid_q && out_q.message_known, out_q.protocol == PROTO_ICMP || (out_q.protocol == PROTO_IGMP && out_q.message_index <= 4'd12))

endmodule
